// ----- rtl/mfir_pkg.sv -----
// ----------------------------------------------------------------------------
// mfir_pkg: shared types and constants
// Register indexes, state codes and fixed field widths for the modulated FIR.
// ----------------------------------------------------------------------------
package mfir_pkg;

    localparam int MAX_TAPS_DEF = 64;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 18;
    localparam int SAMPLE_W   = 16;
    localparam int MOD_W      = 17;
    localparam int COEF_IDX_W = 6;
    localparam int COEF_W     = 16;
    localparam int GAIN_W     = 22;   // modulated Q.14 gains
    localparam int WET_W      = 30;   // eff * amp in Q.14
    localparam int S_W        = 32;   // filter output in Q.8, also quotient width
    localparam int UNITY_Q14  = 16384;

    // register reset values
    localparam logic signed [17:0] EFF_BASE_RST   = 18'sd16384;
    localparam logic        [14:0] RANGE_BASE_RST = 15'd256;
    localparam logic signed [17:0] AMP_BASE_RST   = 18'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EFF_BASE    = 4'd0,
        REG_EFF_DEPTH   = 4'd1,
        REG_RANGE_BASE  = 4'd2,
        REG_RANGE_DEPTH = 4'd3,
        REG_FB_BASE     = 4'd4,
        REG_FB_DEPTH    = 4'd5,
        REG_AMP_BASE    = 4'd6,
        REG_AMP_DEPTH   = 4'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_GAIN,
        ST_WET,
        ST_TAP,
        ST_DRAIN,
        ST_DIV,
        ST_POST1,
        ST_POST2,
        ST_POST3
    } mfir_state_t;

    // divide by 2^22 truncating toward zero, then saturate to 16 bits
    function automatic logic signed [15:0] trunc_clip22(input logic signed [63:0] v);
        logic signed [63:0] adj;
        logic signed [41:0] q;
        adj = v[63] ? v + 64'sd4194303 : v;
        q   = 42'(adj >>> 22);
        if (q > 42'sd32767)
            return 16'sd32767;
        if (q < -42'sd32768)
            return -16'sd32768;
        return q[15:0];
    endfunction

endpackage

// ----- rtl/mfir_ram.sv -----
// ----------------------------------------------------------------------------
// mfir_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module mfir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mfir_div.sv -----
// ----------------------------------------------------------------------------
// mfir_div: serial unsigned divider
// Restoring division, one quotient bit per cycle; quotient known below 2^32.
// ----------------------------------------------------------------------------
module mfir_div
    import mfir_pkg::*;
#(
    parameter int NUM_W = 49,
    parameter int DEN_W = 18
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [S_W-1:0]   quo
);

    localparam int CW = $clog2(S_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [S_W-1:0]   nlo_reg;
    logic [S_W-1:0]   q_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        rem_sh = {rem_reg, nlo_reg[S_W-1]};
        diff   = rem_sh - {1'b0, den_reg};
        ge     = (rem_sh >= {1'b0, den_reg});
    end

    // high part of the dividend is below the divisor, so it seeds the remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DEN_W'(num >> S_W);
            nlo_reg <= num[S_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            nlo_reg <= {nlo_reg[S_W-2:0], 1'b0};
            q_reg   <= {q_reg[S_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(S_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ----- rtl/modulated_fir_with_feedback.sv -----
// ----------------------------------------------------------------------------
// modulated_fir_with_feedback: modulated variable-length FIR with feedback
// Sample history (input and feedback pairs) and coefficients live in two RAMs.
// ----------------------------------------------------------------------------
// Sequence: a coefficient item is written to the table as it is taken. A sample
//   item runs MOD, GAIN, WET, TAP over flen = active taps (1..MAX_TAPS), DRAIN, DIV
//   (serial divider) and POST1..POST3; the tap loop reads one entry of each RAM per cycle.
// Throughput: one sample item at a time; input is taken again once the result
//   sits in the output register, even if it is not yet taken.
// Reset: registers to defaults, then a clear pass over every slot zeroes the history
//   RAM; input is held off during it, config writes are taken at any time.
module modulated_fir_with_feedback
    import mfir_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // config write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    // input item channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic signed [SAMPLE_W-1:0]   sample_in,
    input  logic [MOD_W-1:0]             mod_effect,
    input  logic [MOD_W-1:0]             mod_range,
    input  logic [MOD_W-1:0]             mod_resonance,
    input  logic [COEF_IDX_W-1:0]        coef_index,
    input  logic signed [COEF_W-1:0]     coef_value,
    // result item channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [SAMPLE_W-1:0]   filtered_out
);

    localparam int AB      = $clog2(MAX_TAPS);          // RAM address bits
    localparam int JW      = $clog2(MAX_TAPS + 1);      // tap count bits
    localparam int RNG_MAX = MAX_TAPS * 256;
    localparam int RW      = $clog2(RNG_MAX + 1);       // unsigned Q.8 range bits (Q7.8 at 64 taps)
    localparam int HW      = RW - 8;                    // whole-tap count bits
    localparam int DW      = RW + 3;                    // divisor rng*8
    localparam int AW      = 43 + $clog2(MAX_TAPS);     // accumulator
    localparam int HIST_W  = 2 * SAMPLE_W;              // {input, feedback}

    // ------------------------------------------------------------------
    // Config registers; writes always accepted
    // ------------------------------------------------------------------
    logic signed [17:0] eff_base_reg, eff_depth_reg;
    logic        [14:0] range_base_reg;
    logic signed [15:0] range_depth_reg;
    logic signed [17:0] fb_base_reg, fb_depth_reg;
    logic signed [17:0] amp_base_reg, amp_depth_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_base_reg    <= EFF_BASE_RST;
            eff_depth_reg   <= '0;
            range_base_reg  <= RANGE_BASE_RST;
            range_depth_reg <= '0;
            fb_base_reg     <= '0;
            fb_depth_reg    <= '0;
            amp_base_reg    <= AMP_BASE_RST;
            amp_depth_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_EFF_BASE:    eff_base_reg    <= cfg_data[17:0];
                REG_EFF_DEPTH:   eff_depth_reg   <= cfg_data[17:0];
                REG_RANGE_BASE:  range_base_reg  <= cfg_data[14:0];
                REG_RANGE_DEPTH: range_depth_reg <= cfg_data[15:0];
                REG_FB_BASE:     fb_base_reg     <= cfg_data[17:0];
                REG_FB_DEPTH:    fb_depth_reg    <= cfg_data[17:0];
                REG_AMP_BASE:    amp_base_reg    <= cfg_data[17:0];
                REG_AMP_DEPTH:   amp_depth_reg   <= cfg_data[17:0];
                default:         ;  // unknown index, ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    mfir_state_t state_reg, state_next;
    logic [AB-1:0] clr_reg;
    logic [AB-1:0] wp_reg;         // next history slot to write
    logic [AB-1:0] slot_reg;       // history slot of the tap being read
    logic [JW-1:0] j_reg;          // tap being read, 0 = newest
    logic          p1_valid_reg, p2_valid_reg;
    logic          out_valid_reg;

    // sequencer outputs
    logic          in_take, sample_take, coef_we;
    logic          tap_issue, tap_last, div_start, post_go;
    logic          hist_we;
    logic [AB-1:0] hist_waddr;
    logic [HIST_W-1:0] hist_wdata;

    // datapath
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [MOD_W-1:0]           m1_reg, m2_reg, m3_reg;
    logic signed [35:0]         prod_eff_reg, prod_fb_reg, prod_amp_reg;
    logic signed [33:0]         prod_rng_reg;
    logic signed [GAIN_W-1:0]   eff_reg, fb_reg, amp_reg, dry_reg;
    logic signed [WET_W-1:0]    wet_reg;
    logic [RW-1:0]              rng_reg;
    logic [HW-1:0]              h_reg;
    logic [7:0]                 f_reg;
    logic [JW-1:0]              flen_reg;
    logic                       p1_frac_reg, p1_self_reg;
    logic signed [32:0]         prod1_reg;
    logic [8:0]                 p2_scale_reg;
    logic signed [AW-1:0]       acc_reg;
    logic                       neg_reg;
    logic signed [S_W-1:0]      s_reg;
    logic signed [61:0]         pw_reg;
    logic signed [37:0]         pd_reg;
    logic signed [63:0]         total_reg;
    logic signed [53:0]         pf_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    // RAM ports
    logic [HIST_W-1:0] hist_rdata;
    logic [COEF_W-1:0] coef_rdata;

    // divider
    logic [AW-1:0]  div_num;
    logic [DW-1:0]  div_den;
    logic           div_done;
    logic [S_W-1:0] div_quo;

    // combinational helpers
    logic signed [GAIN_W-1:0] eff_mod, fb_mod, amp_mod;
    logic signed [GAIN_W-1:0] rng_raw;
    logic [RW-1:0]            rng_sat;
    logic signed [43:0]       ea_prod;
    logic signed [16:0]       tap_v;
    logic signed [42:0]       mac_term;
    logic signed [SAMPLE_W-1:0] fb_new;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == AB'(MAX_TAPS - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_valid && !req_type)
                    state_next = ST_MOD;
            ST_MOD:   state_next = ST_GAIN;
            ST_GAIN:  state_next = ST_WET;
            ST_WET:   state_next = ST_TAP;
            ST_TAP:
                if (j_reg == flen_reg - 1'b1)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (!p1_valid_reg && !p2_valid_reg)
                    state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_POST1;
            ST_POST1: state_next = ST_POST2;
            ST_POST2: state_next = ST_POST3;
            ST_POST3:
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        in_take     = in_ready && in_valid;
        sample_take = in_take && !req_type;
        // writes beyond the table are dropped
        coef_we     = in_take && req_type && (int'(coef_index) < MAX_TAPS);
        tap_issue   = (state_reg == ST_TAP);
        tap_last    = tap_issue && (j_reg == flen_reg - 1'b1);
        div_start   = (state_reg == ST_DRAIN) && !p1_valid_reg && !p2_valid_reg;
        post_go     = (state_reg == ST_POST3) && (!out_valid_reg || out_ready);
        hist_we     = (state_reg == ST_CLEAR) || post_go;
        hist_waddr  = (state_reg == ST_CLEAR) ? clr_reg : wp_reg;
        hist_wdata  = (state_reg == ST_CLEAR) ? '0 : {x_reg, fb_new};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            wp_reg        <= '0;
            slot_reg      <= '0;
            j_reg         <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= tap_issue;
            p2_valid_reg <= p1_valid_reg;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_WET)
            begin
                j_reg    <= '0;
                slot_reg <= (wp_reg == '0) ? AB'(MAX_TAPS - 1) : wp_reg - 1'b1;
            end
            else if (tap_issue)
            begin
                j_reg    <= j_reg + 1'b1;
                slot_reg <= (slot_reg == '0) ? AB'(MAX_TAPS - 1) : slot_reg - 1'b1;
            end
            if (post_go)
                wp_reg <= (wp_reg == AB'(MAX_TAPS - 1)) ? '0 : wp_reg + 1'b1;
            if (post_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Modulation and gains
    // ------------------------------------------------------------------
    always_comb
    begin
        eff_mod = GAIN_W'(eff_base_reg) + GAIN_W'(prod_eff_reg >>> 16);
        fb_mod  = -(GAIN_W'(fb_base_reg) + GAIN_W'(prod_fb_reg >>> 16));
        amp_mod = GAIN_W'(amp_base_reg) + GAIN_W'(prod_amp_reg >>> 16);
        rng_raw = GAIN_W'($signed({1'b0, range_base_reg})) + GAIN_W'(prod_rng_reg >>> 16);
        // length saturates to one tap .. MAX_TAPS taps
        if (rng_raw < GAIN_W'(256))
            rng_sat = RW'(256);
        else if (rng_raw > GAIN_W'(RNG_MAX))
            rng_sat = RW'(RNG_MAX);
        else
            rng_sat = RW'(rng_raw);
        ea_prod = eff_reg * amp_reg;
    end

    // ------------------------------------------------------------------
    // Tap datapath: read, add history pair, multiply, scale and accumulate
    // ------------------------------------------------------------------
    always_comb
    begin
        // the oldest tap at full length sees the sample of this item
        tap_v    = (p1_self_reg ? 17'(x_reg) : 17'($signed(hist_rdata[HIST_W-1:SAMPLE_W])))
                 + 17'($signed(hist_rdata[SAMPLE_W-1:0]));
        mac_term = prod1_reg * $signed({1'b0, p2_scale_reg});
        div_num  = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
        div_den  = {rng_reg, 3'b000};
        fb_new   = trunc_clip22(64'(pf_reg));
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            x_reg  <= sample_in;
            m1_reg <= mod_effect;
            m2_reg <= mod_range;
            m3_reg <= mod_resonance;
        end
        if (state_reg == ST_MOD)
        begin
            prod_eff_reg <= eff_depth_reg * $signed({1'b0, m1_reg});
            prod_rng_reg <= range_depth_reg * $signed({1'b0, m2_reg});
            prod_fb_reg  <= fb_depth_reg * $signed({1'b0, m3_reg});
            prod_amp_reg <= amp_depth_reg * $signed({1'b0, m3_reg});
        end
        if (state_reg == ST_GAIN)
        begin
            eff_reg <= eff_mod;
            fb_reg  <= fb_mod;
            amp_reg <= amp_mod;
            rng_reg <= rng_sat;
        end
        if (state_reg == ST_WET)
        begin
            wet_reg  <= WET_W'(ea_prod >>> 14);
            dry_reg  <= GAIN_W'(UNITY_Q14) - eff_reg;
            h_reg    <= rng_reg[RW-1:8];
            f_reg    <= rng_reg[7:0];
            flen_reg <= JW'(rng_reg[RW-1:8]) + JW'(rng_reg[7:0] != 8'd0);
            acc_reg  <= '0;
        end
        if (tap_issue)
        begin
            p1_frac_reg <= (j_reg == JW'(h_reg));
            p1_self_reg <= (slot_reg == wp_reg);
        end
        if (p1_valid_reg)
        begin
            prod1_reg    <= $signed(coef_rdata) * tap_v;
            p2_scale_reg <= p1_frac_reg ? {1'b0, f_reg} : 9'd256;
        end
        if (p2_valid_reg)
            acc_reg <= acc_reg + AW'(mac_term);
        if (div_start)
            neg_reg <= acc_reg[AW-1];
        if (div_done)
            s_reg <= neg_reg ? -$signed(div_quo) : $signed(div_quo);
        if (state_reg == ST_POST1)
        begin
            pw_reg <= s_reg * wet_reg;
            pd_reg <= x_reg * dry_reg;
        end
        if (state_reg == ST_POST2)
        begin
            total_reg <= (64'(pd_reg) <<< 8) + 64'(pw_reg);
            pf_reg    <= s_reg * fb_reg;
        end
        if (post_go)
            out_reg <= trunc_clip22(total_reg);
    end

    // ------------------------------------------------------------------
    // Memories and divider
    // ------------------------------------------------------------------
    mfir_ram #(
        .WIDTH (HIST_W),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (tap_issue),
        .raddr (slot_reg),
        .rdata (hist_rdata)
    );

    mfir_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (AB'(coef_index)),
        .wdata (coef_value),
        .re    (tap_issue),
        .raddr (AB'(j_reg)),
        .rdata (coef_rdata)
    );

    mfir_div #(
        .NUM_W (AW),
        .DEN_W (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign out_valid    = out_valid_reg;
    assign filtered_out = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("input taken during history clear");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");

    a_no_write_in_taps: assert property (@(posedge clk) disable iff (!rst_n)
        hist_we |-> (!tap_issue && !p1_valid_reg && !p2_valid_reg))
        else $error("history write overlaps tap loop");

    a_last_tap_drains: assert property (@(posedge clk) disable iff (!rst_n)
        tap_last |=> (state_reg == ST_DRAIN && p1_valid_reg))
        else $error("tap loop did not hand over to drain");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for modulated_fir_with_feedback
// Loads the coefficient table, then runs directed and random sample items
// through several register settings. A local filter model predicts each
// output sample, and a monitor compares results in order under random
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import mfir_pkg::*;

    localparam int                   TAPS         = MAX_TAPS_DEF;
    localparam logic                 REQ_SAMPLE   = 1'b0;
    localparam logic                 REQ_COEF     = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 4'd11;   // unmapped index
    localparam int                   DRAIN_CYC    = 150;     // quiet time after the last result

    // register widths and signedness, in index order
    localparam int REG_W [8] = '{18, 18, 15, 16, 18, 18, 18, 18};
    localparam bit REG_S [8] = '{1, 1, 0, 1, 1, 1, 1, 1};

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       req_type = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic [MOD_W-1:0]           mod_effect = '0;
    logic [MOD_W-1:0]           mod_range = '0;
    logic [MOD_W-1:0]           mod_resonance = '0;
    logic [COEF_IDX_W-1:0]      coef_index = '0;
    logic signed [COEF_W-1:0]   coef_value = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] filtered_out;

    modulated_fir_with_feedback DUT (.*);

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // --- filter model state --------------------------------------------------
    logic [17:0]                fir_regs [8];
    logic signed [15:0]         hist_in [TAPS];
    logic signed [15:0]         hist_fb [TAPS];
    logic signed [15:0]         coefs [TAPS];
    logic [5:0]                 wr_pos;
    logic signed [15:0]         expected_samples [$];
    int                         fail_count = 0;

    // sender burst control and receiver stall control
    int burst_left = 0;
    int max_gap    = 8;
    int stall_pct  = 20;
    int stall_left = 0;

    function automatic longint reg_value(int i);
        longint raw;
        raw = longint'(fir_regs[i]) & ((64'sd1 <<< REG_W[i]) - 1);
        if (REG_S[i] && raw[REG_W[i]-1])
            raw = raw - (64'sd1 <<< REG_W[i]);
        return raw;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // one sample through the filter: updates history, returns the output
    function automatic logic signed [15:0] filter_sample(
        logic signed [15:0] x_in, logic [16:0] me, logic [16:0] mr, logic [16:0] mres);
        longint x, eff, dry, rng, fb, amp, wet, acc, s, v, total, fbv;
        int     h, f, flen, slot;
        x   = x_in;
        eff = reg_value(0) + ((reg_value(1) * longint'(me)) >>> 16);
        dry = UNITY_Q14 - eff;
        rng = reg_value(2) + ((reg_value(3) * longint'(mr)) >>> 16);
        if (rng < 256)
            rng = 256;
        if (rng > TAPS * 256)
            rng = TAPS * 256;
        fb  = -(reg_value(4) + ((reg_value(5) * longint'(mres)) >>> 16));
        amp = reg_value(6) + ((reg_value(7) * longint'(mres)) >>> 16);
        wet = (eff * amp) >>> 14;
        h    = int'(rng >>> 8);
        f    = int'(rng & 255);
        flen = h + ((f != 0) ? 1 : 0);
        // new sample lands before the taps are read (full length sees it)
        hist_in[wr_pos] = x_in;
        acc = 0;
        for (int j = 0; j < flen; j++)
        begin
            slot = (int'(wr_pos) + TAPS - 1 - j) % TAPS;
            v    = longint'(hist_in[slot]) + longint'(hist_fb[slot]);
            if (j < h)
                acc += longint'(coefs[j]) * v * 256;
            else
                acc += longint'(f) * longint'(coefs[j]) * v;   // fractional last tap
        end
        s     = acc / (rng * 8);
        total = x * dry * 256 + s * wet;
        fbv   = clip16((s * fb) / 4194304);
        hist_fb[wr_pos] = fbv[15:0];
        wr_pos = wr_pos + 1'b1;
        return 16'(clip16(total / 4194304));
    endfunction

    // --- result monitor --------------------------------------------------------
    always @(posedge clk)
    begin
        logic signed [15:0] exp_val;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("filtered_out: no item expected, actual %0d", filtered_out);
                fail_count++;
            end
            else
            begin
                exp_val = expected_samples.pop_front();
                if (filtered_out !== exp_val)
                begin
                    $error("filtered_out: expected %0d, actual %0d", exp_val, filtered_out);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls in short random runs; stall_pct 0 gives clean stretches
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(99) < stall_pct)
                stall_left = $urandom_range(1, 12);
        end
    end

    // --- shared tasks --------------------------------------------------------
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx < 8)
            fir_regs[idx] = val & ((18'd1 << REG_W[idx]) - 1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(logic rt, logic signed [15:0] smp, logic [16:0] me,
                             logic [16:0] mr, logic [16:0] mres, logic [5:0] ci,
                             logic signed [15:0] cv);
        @(negedge clk);
        if (burst_left == 0)
        begin
            // gap between bursts, sometimes a long unbroken burst
            in_valid <= 1'b0;
            repeat ($urandom_range(1, max_gap)) @(negedge clk);
            burst_left = ($urandom_range(9) == 0) ? 200 : $urandom_range(1, 16);
        end
        req_type      <= rt;
        sample_in     <= smp;
        mod_effect    <= me;
        mod_range     <= mr;
        mod_resonance <= mres;
        coef_index    <= ci;
        coef_value    <= cv;
        in_valid      <= 1'b1;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        if (rt == REQ_COEF)
            coefs[ci] = cv;
        else
            expected_samples.push_back(filter_sample(smp, me, mr, mres));
    endtask

    // registers change only once the block has gone quiet
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    function automatic logic [16:0] rand_mod();
        // mostly 0 to 1.0 in Q1.16, sometimes any 17-bit value
        return ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
    endfunction

    task automatic send_random_sample();
        send_item(REQ_SAMPLE, 16'($urandom), rand_mod(), rand_mod(), rand_mod(), '0, '0);
    endtask

    // --- tests ---------------------------------------------------------------
    // every slot is written before any sample can read it
    task automatic test_coef_load();
        for (int i = 0; i < TAPS; i++)
            send_item(REQ_COEF, 16'($urandom), '0, '0, '0, 6'(i), 16'($urandom_range(4095)) - 16'sd2048);
        wait_quiet();
    endtask

    task automatic test_directed();
        // full length, fractional tap, feedback and unmapped register
        cfg_write(REG_EFF_BASE,    18'sd8192);
        cfg_write(REG_EFF_DEPTH,   18'sd4096);
        cfg_write(REG_RANGE_BASE,  18'd16384);
        cfg_write(REG_RANGE_DEPTH, -18'sd300);
        cfg_write(REG_FB_BASE,     -18'sd8000);
        cfg_write(REG_FB_DEPTH,    18'sd2000);
        cfg_write(REG_AMP_BASE,    18'sd16384);
        cfg_write(REG_AMP_DEPTH,   -18'sd4096);
        cfg_write(CFG_IDX_NONE,    18'h3FFFF);
        send_item(REQ_SAMPLE, 16'sh7FFF, 17'd0, 17'd0, 17'd0, '0, '0);
        send_item(REQ_SAMPLE, 16'sh8000, 17'd65536, 17'd65536, 17'd65536, '0, '0);
        send_item(REQ_SAMPLE, 16'sd0, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, '0, '0);
        send_item(REQ_COEF, '0, '0, '0, '0, 6'd0, 16'sh7FFF);
        send_item(REQ_COEF, '0, '0, '0, '0, 6'd63, 16'sh8000);
        send_item(REQ_SAMPLE, 16'sh7FFF, 17'd0, 17'd32768, 17'd65536, '0, '0);
        send_item(REQ_SAMPLE, 16'sh8000, 17'd65536, 17'd0, 17'd0, '0, '0);
        send_item(REQ_SAMPLE, 16'sd1, 17'd12345, 17'd54321, 17'd777, '0, '0);
        wait_quiet();
        // register extremes
        cfg_write(REG_EFF_BASE,    18'h1FFFF);
        cfg_write(REG_EFF_DEPTH,   18'h20000);
        cfg_write(REG_RANGE_BASE,  18'h3FFFF);           // above range, saturates
        cfg_write(REG_RANGE_DEPTH, 18'h8000);
        cfg_write(REG_FB_BASE,     18'h20000);
        cfg_write(REG_FB_DEPTH,    18'h1FFFF);
        cfg_write(REG_AMP_BASE,    18'h20000);
        cfg_write(REG_AMP_DEPTH,   18'h1FFFF);
        for (int i = 0; i < 8; i++)
            send_item(REQ_SAMPLE, (i[0] ? 16'sh7FFF : 16'sh8000), rand_mod(),
                      (i < 4) ? 17'd0 : 17'h1FFFF, rand_mod(), '0, '0);
        wait_quiet();
    endtask

    task automatic test_random(int phases, int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            cfg_write(REG_EFF_BASE,    18'($urandom_range(32768)) - 18'sd8192);
            cfg_write(REG_EFF_DEPTH,   18'($urandom));
            cfg_write(REG_RANGE_BASE,  18'($urandom_range(16384)));
            cfg_write(REG_RANGE_DEPTH, 18'($urandom_range(32768)) - 18'sd16384);
            cfg_write(REG_FB_BASE,     18'($urandom_range(32768)) - 18'sd16384);
            cfg_write(REG_FB_DEPTH,    ($urandom_range(3) == 0) ? 18'($urandom) : '0);
            cfg_write(REG_AMP_BASE,    18'($urandom));
            cfg_write(REG_AMP_DEPTH,   18'($urandom));
            stall_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 60);
            max_gap   = (p % 3 == 1) ? 1 : $urandom_range(2, 30);
            for (int n = 0; n < per_phase; n++)
            begin
                if ($urandom_range(9) == 0)
                    send_item(REQ_COEF, 16'($urandom), rand_mod(), rand_mod(), rand_mod(),
                              6'($urandom), 16'($urandom));
                else
                    send_random_sample();
            end
            wait_quiet();
        end
    endtask

    // --- main sequence -------------------------------------------------------
    initial
    begin
        fir_regs = '{18'd16384, 18'd0, 18'd256, 18'd0, 18'd0, 18'd0, 18'd16384, 18'd0};
        foreach (hist_in[i])
        begin
            hist_in[i] = '0;
            hist_fb[i] = '0;
            coefs[i]   = '0;
        end
        wr_pos = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_coef_load();
        test_directed();
        test_random(6, 195);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- modulated_fir_with_feedback.f -----
rtl/mfir_pkg.sv
rtl/mfir_ram.sv
rtl/mfir_div.sv
rtl/modulated_fir_with_feedback.sv
sim/tb_top.sv
